### design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PPD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define PPD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### design/ppd_pkg.sv
`default_nettype none
package ppd_pkg;
    // Coordinate and length widths.
    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int SRC_W   = PROD_W;
    localparam int ROOT_W  = DIFF_W;
    localparam int REM_W   = ROOT_W + 3;
    localparam int LEN_W   = 40;
    localparam int CNT_W   = 7;
    localparam int SQRT_STEPS = SRC_W / 2;
    localparam int DIV_STEPS  = SRC_W;
    localparam int OP_LAST    = 11;

    // Jobs of the shared root and divide unit.
    typedef enum logic [2:0] {
        JOB_LEN,
        JOB_DA,
        JOB_DB,
        JOB_DC,
        JOB_DP
    } t_job;
endpackage
`default_nettype wire

### design/polyline_projection_distance.sv
`default_nettype none
// Channel   Dir   tdata (low bit up)                         tuser          tlast
// s_axis    in    query_x, query_y, vertex_x, vertex_y       first_vertex   last_vertex
// m_axis    out   along_distance, nearest_distance           no_segment     -
//
// A vertex without a previous one skips the arithmetic; a segment uses the shared
// multiplier, then 3 square roots of 33 steps and up to 2 divisions of 66 steps
// on the bit-serial root and divide unit.
// Reset is synchronous and active low; there is no clearing pass.
// A result waits in the output register; the last vertex's update holds while it is full and not taken.
module polyline_projection_distance import ppd_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [127:0] s_axis_tdata,  // query_x, query_y, vertex_x, vertex_y
    input  wire logic         s_axis_tuser,  // first_vertex
    input  wire logic         s_axis_tlast,  // last_vertex
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [79:0]       m_axis_tdata,  // along_distance, nearest_distance
    output logic              m_axis_tuser   // no_segment
);
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_UNIT,
        ST_FIN
    } t_state;

    localparam logic [LEN_W-1:0] LEN_ONES = {LEN_W{1'b1}};

    t_state r_state;
    logic [COORD_W-1:0] r_prev_x, r_prev_y, r_vx, r_vy;
    logic r_have_prev, r_last, r_seg;
    logic [LEN_W-1:0] r_run, r_best_dist, r_best_along;
    logic signed [DIFF_W-1:0] r_abx, r_aby, r_apx, r_apy, r_bpx, r_bpy;
    logic [3:0] r_op;
    logic r_phase;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0] r_acc_l, r_acc_a, r_acc_b, r_acc_d1, r_acc_d2, r_acc_c;
    t_job r_job;
    logic [REM_W-1:0] r_rem;
    logic [SRC_W-1:0] r_src, r_res;
    logic [CNT_W-1:0] r_cnt;
    logic [ROOT_W-1:0] r_len, r_da, r_dist, r_proj;
    logic r_m_valid, r_m_noseg;
    logic [LEN_W-1:0] r_m_along, r_m_near;

    // Input differences, taken against the stored previous vertex.
    logic signed [DIFF_W-1:0] w_qx, w_qy, w_vx, w_vy, w_ax, w_ay;
    assign w_qx = DIFF_W'(signed'(s_axis_tdata[31:0]));
    assign w_qy = DIFF_W'(signed'(s_axis_tdata[63:32]));
    assign w_vx = DIFF_W'(signed'(s_axis_tdata[95:64]));
    assign w_vy = DIFF_W'(signed'(s_axis_tdata[127:96]));
    assign w_ax = DIFF_W'(signed'(r_prev_x));
    assign w_ay = DIFF_W'(signed'(r_prev_y));

    // Operand selection for the shared multiplier.
    logic signed [DIFF_W-1:0] w_ma, w_mb;
    always_comb begin
        case (r_op)
            4'd0:    begin w_ma = r_abx; w_mb = r_abx; end
            4'd1:    begin w_ma = r_aby; w_mb = r_aby; end
            4'd2:    begin w_ma = r_apx; w_mb = r_apx; end
            4'd3:    begin w_ma = r_apy; w_mb = r_apy; end
            4'd4:    begin w_ma = r_bpx; w_mb = r_bpx; end
            4'd5:    begin w_ma = r_bpy; w_mb = r_bpy; end
            4'd6:    begin w_ma = r_apx; w_mb = r_abx; end
            4'd7:    begin w_ma = r_apy; w_mb = r_aby; end
            4'd8:    begin w_ma = r_bpx; w_mb = r_abx; end
            4'd9:    begin w_ma = r_bpy; w_mb = r_aby; end
            4'd10:   begin w_ma = r_abx; w_mb = r_apy; end
            default: begin w_ma = r_apx; w_mb = r_aby; end
        endcase
    end

    logic signed [ACC_W-1:0] w_pext;
    assign w_pext = ACC_W'(r_prod);

    // One step of the bit-serial square root or restoring division.
    logic w_sqrt;
    logic [REM_W-1:0] w_rs, w_trial, w_diff, n_rem;
    logic w_ge;
    logic [SRC_W-1:0] n_res;
    always_comb begin
        w_sqrt = (r_job == JOB_LEN) || (r_job == JOB_DA) || (r_job == JOB_DB);
        if (w_sqrt) begin
            w_rs    = {r_rem[REM_W-3:0], r_src[SRC_W-1 -: 2]};
            w_trial = {r_res[REM_W-3:0], 2'b01};
        end else begin
            w_rs    = {r_rem[REM_W-2:0], r_src[SRC_W-1]};
            w_trial = REM_W'(r_len);
        end
        w_ge   = (w_rs >= w_trial);
        w_diff = w_rs - w_trial;
        n_rem  = w_ge ? w_diff : w_rs;
        n_res  = {r_res[SRC_W-2:0], w_ge};
    end

    // Signs and magnitudes of the dot and cross products.
    logic w_d1pos, w_d2pos;
    logic signed [ACC_W-1:0] w_cneg;
    logic [SRC_W-1:0] w_cmag;
    logic [ROOT_W-1:0] w_dmin;
    assign w_d1pos = !r_acc_d1[ACC_W-1] && (r_acc_d1 != '0);
    assign w_d2pos = !r_acc_d2[ACC_W-1] && (r_acc_d2 != '0);
    assign w_cneg  = -r_acc_c;
    assign w_cmag  = r_acc_c[ACC_W-1] ? w_cneg[SRC_W-1:0] : r_acc_c[SRC_W-1:0];
    assign w_dmin  = (n_res[ROOT_W-1:0] < r_da) ? n_res[ROOT_W-1:0] : r_da;

    // Line state update at the end of an item.
    logic w_better, w_slot;
    logic [LEN_W:0] w_along_sum, w_run_sum;
    logic [LEN_W-1:0] n_best_dist, n_best_along, n_run;
    always_comb begin
        w_better    = r_seg && (LEN_W'(r_dist) < r_best_dist);
        w_along_sum = {1'b0, r_run} + (LEN_W + 1)'(r_proj);
        w_run_sum   = {1'b0, r_run} + (LEN_W + 1)'(r_len);
        n_best_dist  = w_better ? LEN_W'(r_dist) : r_best_dist;
        n_best_along = r_best_along;
        if (w_better) begin
            n_best_along = w_along_sum[LEN_W] ? LEN_ONES : w_along_sum[LEN_W-1:0];
        end
        n_run = r_run;
        if (r_seg) begin
            n_run = w_run_sum[LEN_W] ? LEN_ONES : w_run_sum[LEN_W-1:0];
        end
        w_slot = !r_m_valid || m_axis_tready;
    end

    // Sequencer, datapath and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_prev_x     <= '0;
            r_prev_y     <= '0;
            r_have_prev  <= 1'b0;
            r_run        <= '0;
            r_best_dist  <= LEN_ONES;
            r_best_along <= '0;
            r_m_valid    <= 1'b0;
        end else begin
            // A taken result frees the output register unless a new one lands now.
            if (m_axis_tready && !((r_state == ST_FIN) && r_last)) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_vx   <= s_axis_tdata[95:64];
                        r_vy   <= s_axis_tdata[127:96];
                        r_last <= s_axis_tlast;
                        r_abx  <= w_vx - w_ax;
                        r_aby  <= w_vy - w_ay;
                        r_apx  <= w_qx - w_ax;
                        r_apy  <= w_qy - w_ay;
                        r_bpx  <= w_qx - w_vx;
                        r_bpy  <= w_qy - w_vy;
                        r_op     <= '0;
                        r_phase  <= 1'b0;
                        r_acc_l  <= '0;
                        r_acc_a  <= '0;
                        r_acc_b  <= '0;
                        r_acc_d1 <= '0;
                        r_acc_d2 <= '0;
                        r_acc_c  <= '0;
                        r_seg    <= r_have_prev && !s_axis_tuser;
                        if (s_axis_tuser) begin
                            r_run        <= '0;
                            r_best_dist  <= LEN_ONES;
                            r_best_along <= '0;
                        end
                        r_state <= (r_have_prev && !s_axis_tuser) ? ST_MUL : ST_FIN;
                    end
                end
                ST_MUL: begin
                    r_phase <= !r_phase;
                    if (!r_phase) begin
                        r_prod <= w_ma * w_mb;
                    end else begin
                        case (r_op)
                            4'd0, 4'd1: r_acc_l  <= r_acc_l + w_pext;
                            4'd2, 4'd3: r_acc_a  <= r_acc_a + w_pext;
                            4'd4, 4'd5: r_acc_b  <= r_acc_b + w_pext;
                            4'd6, 4'd7: r_acc_d1 <= r_acc_d1 + w_pext;
                            4'd8, 4'd9: r_acc_d2 <= r_acc_d2 - w_pext;
                            4'd10:      r_acc_c  <= r_acc_c + w_pext;
                            default:    r_acc_c  <= r_acc_c - w_pext;
                        endcase
                        r_op <= r_op + 4'd1;
                        if (r_op == 4'(OP_LAST)) begin
                            r_src   <= r_acc_l[SRC_W-1:0];
                            r_rem   <= '0;
                            r_res   <= '0;
                            r_cnt   <= CNT_W'(SQRT_STEPS);
                            r_job   <= JOB_LEN;
                            r_state <= ST_UNIT;
                        end
                    end
                end
                ST_UNIT: begin
                    r_rem <= n_rem;
                    r_res <= n_res;
                    r_src <= w_sqrt ? {r_src[SRC_W-3:0], 2'b00} : {r_src[SRC_W-2:0], 1'b0};
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_rem <= '0;
                        r_res <= '0;
                        case (r_job)
                            JOB_LEN: begin
                                r_len <= n_res[ROOT_W-1:0];
                                r_src <= r_acc_a[SRC_W-1:0];
                                r_cnt <= CNT_W'(SQRT_STEPS);
                                r_job <= JOB_DA;
                            end
                            JOB_DA: begin
                                r_da  <= n_res[ROOT_W-1:0];
                                r_src <= r_acc_b[SRC_W-1:0];
                                r_cnt <= CNT_W'(SQRT_STEPS);
                                r_job <= JOB_DB;
                            end
                            JOB_DB: begin
                                r_dist <= w_dmin;
                                r_proj <= '0;
                                r_cnt  <= CNT_W'(DIV_STEPS);
                                if (w_d1pos && w_d2pos && (r_len != '0)) begin
                                    r_src <= w_cmag;
                                    r_job <= JOB_DC;
                                end else if (w_d1pos && (r_len != '0)) begin
                                    r_src <= r_acc_d1[SRC_W-1:0];
                                    r_job <= JOB_DP;
                                end else begin
                                    r_state <= ST_FIN;
                                end
                            end
                            JOB_DC: begin
                                if (n_res < SRC_W'(r_dist)) begin
                                    r_dist <= n_res[ROOT_W-1:0];
                                end
                                r_src <= r_acc_d1[SRC_W-1:0];
                                r_cnt <= CNT_W'(DIV_STEPS);
                                r_job <= JOB_DP;
                            end
                            default: begin
                                r_proj  <= (n_res < SRC_W'(r_len)) ? n_res[ROOT_W-1:0] : r_len;
                                r_state <= ST_FIN;
                            end
                        endcase
                    end
                end
                ST_FIN: begin
                    if (!r_last || w_slot) begin
                        r_prev_x <= r_vx;
                        r_prev_y <= r_vy;
                        r_state  <= ST_IDLE;
                        if (r_last) begin
                            r_m_valid    <= 1'b1;
                            r_m_along    <= n_best_along;
                            r_m_near     <= n_best_dist;
                            r_m_noseg    <= !r_seg;
                            r_have_prev  <= 1'b0;
                            r_run        <= '0;
                            r_best_dist  <= LEN_ONES;
                            r_best_along <= '0;
                        end else begin
                            r_have_prev  <= 1'b1;
                            r_run        <= n_run;
                            r_best_dist  <= n_best_dist;
                            r_best_along <= n_best_along;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {r_m_near, r_m_along};
    assign m_axis_tuser  = r_m_noseg;
endmodule
`default_nettype wire

### design/ppd_checker.sv
`default_nettype none
`include "assert_macros.svh"
// Port-level checks on the projection block.
module ppd_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [79:0]  m_axis_tdata,
    input wire logic         m_axis_tuser
);
    // A held result stays until it is taken.
    `PPD_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    // An accepted vertex makes the block busy in the next cycle.
    `PPD_ASSERT_NXT(a_busy_after_req, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // A lone vertex reports a zero along distance and an all-ones distance.
    `PPD_ASSERT_NOW(a_noseg_vals, m_axis_tvalid && m_axis_tuser,
        (m_axis_tdata[79:40] == 40'hFF_FFFF_FFFF) && (m_axis_tdata[39:0] == 40'd0))
    // A real segment distance fits in the root width.
    `PPD_ASSERT_NOW(a_dist_range, m_axis_tvalid && !m_axis_tuser,
        m_axis_tdata[79:73] == 7'd0)
endmodule

bind polyline_projection_distance ppd_checker u_ppd_checker (.*);
`default_nettype wire
